// ----- sv/sdsh_pkg.sv -----
// Shared types, constants and command tables of the SD card SPI host engine.
package sdsh_pkg;

  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned MAX_BLOCKS_DEF = 128;
  localparam int unsigned BLOCK_CNT_W = $clog2(BLOCK_BYTES + 1);

  // Configuration register indexes (byte address divided by four).
  localparam logic [1:0] REG_CMD_RETRY = 2'd0;
  localparam logic [1:0] REG_RESP_POLL = 2'd1;
  localparam logic [1:0] REG_INIT_ATTEMPT = 2'd2;
  localparam logic [1:0] REG_READY_WAIT = 2'd3;

  localparam logic [7:0] CMD_RETRY_RST = 8'd10;
  localparam logic [7:0] RESP_POLL_RST = 8'd10;
  localparam logic [15:0] INIT_ATTEMPT_RST = 16'd255;
  localparam logic [23:0] READY_WAIT_RST = 24'd1000000;

  // Request kinds.
  localparam logic [2:0] OP_INIT = 3'd0;
  localparam logic [2:0] OP_READ = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_SYNC = 3'd3;
  localparam logic [2:0] OP_STATUS = 3'd4;

  // Completion codes.
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_PARAM = 2'd1;
  localparam logic [1:0] ST_NOT_READY = 2'd2;
  localparam logic [1:0] ST_ERROR = 2'd3;

  // Command table entries.
  localparam logic [3:0] LC_RESET = 4'd0;
  localparam logic [3:0] LC_IFCOND = 4'd1;
  localparam logic [3:0] LC_OCR_FIRST = 4'd2;
  localparam logic [3:0] LC_APP = 4'd3;
  localparam logic [3:0] LC_APP_OPCOND = 4'd4;
  localparam logic [3:0] LC_OPCOND = 4'd5;
  localparam logic [3:0] LC_OCR_LAST = 4'd6;
  localparam logic [3:0] LC_READ_ONE = 4'd7;
  localparam logic [3:0] LC_READ_MANY = 4'd8;
  localparam logic [3:0] LC_STOP = 4'd9;
  localparam logic [3:0] LC_WRITE_ONE = 4'd10;
  localparam logic [3:0] LC_COUNT = 4'd11;

  // Answer kinds.
  localparam logic [1:0] AK_R1 = 2'd0;
  localparam logic [1:0] AK_R7 = 2'd1;
  localparam logic [1:0] AK_R7_ILLEGAL = 2'd2;
  localparam logic [1:0] AK_R1_ZERO = 2'd3;

  localparam logic [7:0] TOKEN_START = 8'hFE;
  localparam logic [7:0] IDLE_BYTE = 8'hFF;
  localparam logic [3:0] DATA_ACCEPTED = 4'h5;

  typedef enum logic [5:0] {
    PH_IDLE, PH_WAKE, PH_FRAME, PH_STUFF, PH_R1, PH_TAIL, PH_TOKEN,
    PH_RDATA, PH_RCRC, PH_SETTLE_OK, PH_SETTLE_ERR, PH_SYNC, PH_WPRE,
    PH_WTOKEN, PH_WDATA, PH_WCRC, PH_WRESP, PH_WBUSY
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic [3:0] command_index;
    logic [3:0] frame_counter;
    logic [31:0] command_argument;
    logic [39:0] response_bytes;
    logic [7:0] attempt_counter;
    logic [23:0] poll_counter;
    logic [15:0] init_counter;
    logic [BLOCK_CNT_W-1:0] byte_counter;
    logic [7:0] blocks_left;
    logic [31:0] card_address;
    logic version_two_card;
    logic uses_block_address;
    logic ready_flag;
  } sdsh_state_t;

  typedef struct packed {
    logic [7:0] cmd_retry;
    logic [7:0] resp_poll;
    logic [15:0] init_attempt;
    logic [23:0] ready_wait;
  } sdsh_limits_t;

  typedef struct packed {
    logic [7:0] mosi_byte;
    logic exchange_request;
    logic chip_select_low;
    logic [7:0] read_data;
    logic read_valid;
    logic write_taken;
    logic done_res;
    logic [1:0] status;
    logic initialized;
    logic block_addressing;
    logic fast_clock;
  } sdsh_result_t;

  function automatic logic [3:0] cmd_sel(logic [3:0] idx);
    return (idx < LC_COUNT) ? idx : LC_RESET;
  endfunction

  function automatic logic [7:0] lc_opcode(logic [3:0] c);
    logic [7:0] r;
    unique case (c)
      LC_IFCOND: r = 8'd8;
      LC_OCR_FIRST, LC_OCR_LAST: r = 8'd58;
      LC_APP: r = 8'd55;
      LC_APP_OPCOND: r = 8'd41;
      LC_OPCOND: r = 8'd1;
      LC_READ_ONE: r = 8'd17;
      LC_READ_MANY: r = 8'd18;
      LC_STOP: r = 8'd12;
      LC_WRITE_ONE: r = 8'd24;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] lc_crc(logic [3:0] c);
    logic [7:0] r;
    unique case (c)
      LC_RESET: r = 8'h95;
      LC_IFCOND: r = 8'h87;
      default: r = 8'h01;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] lc_kind(logic [3:0] c);
    logic [1:0] r;
    unique case (c)
      LC_IFCOND: r = AK_R7_ILLEGAL;
      LC_OCR_FIRST, LC_OCR_LAST: r = AK_R7;
      LC_WRITE_ONE: r = AK_R1_ZERO;
      default: r = AK_R1;
    endcase
    return r;
  endfunction

  function automatic sdsh_state_t start_cmd(sdsh_state_t s, logic [3:0] lc,
                                            logic [31:0] arg);
    sdsh_state_t r;
    r = s;
    r.command_index = lc;
    r.command_argument = arg;
    r.attempt_counter = '0;
    r.frame_counter = '0;
    r.response_bytes = {IDLE_BYTE, 32'h0};
    r.phase = PH_FRAME;
    return r;
  endfunction

endpackage

// ----- sv/sdsh_cfg.sv -----
// APB-style register file holding the retry, poll, init-attempt and wait limits.
module sdsh_cfg
  import sdsh_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output sdsh_limits_t limits
);

  sdsh_limits_t lim_r;
  logic [1:0]   idx;

  assign idx = paddr[3:2];
  assign limits = lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r.cmd_retry <= CMD_RETRY_RST;
      lim_r.resp_poll <= RESP_POLL_RST;
      lim_r.init_attempt <= INIT_ATTEMPT_RST;
      lim_r.ready_wait <= READY_WAIT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_CMD_RETRY: lim_r.cmd_retry <= pwdata[7:0];
        REG_RESP_POLL: lim_r.resp_poll <= pwdata[7:0];
        REG_INIT_ATTEMPT: lim_r.init_attempt <= pwdata[15:0];
        REG_READY_WAIT: lim_r.ready_wait <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CMD_RETRY: prdata = {24'h0, lim_r.cmd_retry};
      REG_RESP_POLL: prdata = {24'h0, lim_r.resp_poll};
      REG_INIT_ATTEMPT: prdata = {16'h0, lim_r.init_attempt};
      REG_READY_WAIT: prdata = {8'h0, lim_r.ready_wait};
      default: prdata = '0;
    endcase
  end

endmodule

// ----- sv/sdsh_step.sv -----
// Next-state and result logic for one transaction of the host sequencer.
module sdsh_step
  import sdsh_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  sdsh_state_t  cur,
  input  sdsh_limits_t limits,
  input  logic         mode,
  input  logic [2:0]   operation,
  input  logic [7:0]   drive,
  input  logic [31:0]  start_sector,
  input  logic [7:0]   block_count,
  input  logic [7:0]   miso_byte,
  input  logic [7:0]   write_byte,
  output sdsh_state_t  nxt,
  output sdsh_result_t res
);

  localparam logic [7:0] MAX_BLK = 8'(MAX_BLOCKS);
  localparam logic [BLOCK_CNT_W-1:0] BLK_BYTES = BLOCK_CNT_W'(BLOCK_BYTES);
  localparam logic [BLOCK_CNT_W-1:0] BLK_STEP = BLOCK_CNT_W'(1);

  always_comb begin
    sdsh_state_t n;
    logic        ignored, busy, att, cmd_done, done, rvalid;
    logic [1:0]  st;
    logic [7:0]  r1, mosi;
    logic [3:0]  c;
    logic        acc;
    n = cur;
    ignored = 1'b0;
    att = 1'b0;
    cmd_done = 1'b0;
    done = 1'b0;
    rvalid = 1'b0;
    st = ST_OK;
    r1 = '0;
    c = '0;
    acc = 1'b0;
    mosi = IDLE_BYTE;

    if (!mode) begin
      if (cur.phase != PH_IDLE) begin
        ignored = 1'b1;
      end else if (operation > OP_STATUS || drive != 8'd0) begin
        done = 1'b1; st = ST_PARAM;
      end else begin
        unique case (operation)
          OP_INIT: begin
            n.ready_flag = 1'b0; n.version_two_card = 1'b0;
            n.uses_block_address = 1'b0; n.frame_counter = '0; n.phase = PH_WAKE;
          end
          OP_READ, OP_WRITE: begin
            if (block_count == 8'd0 || block_count > MAX_BLK) begin
              done = 1'b1; st = ST_PARAM;
            end else if (!cur.ready_flag) begin
              done = 1'b1; st = ST_NOT_READY;
            end else begin
              n.blocks_left = block_count;
              n.card_address = cur.uses_block_address ? start_sector
                                                      : {start_sector[22:0], 9'h0};
              if (operation == OP_WRITE) n = start_cmd(n, LC_WRITE_ONE, n.card_address);
              else n = start_cmd(n, (block_count == 8'd1) ? LC_READ_ONE : LC_READ_MANY,
                                 n.card_address);
            end
          end
          OP_SYNC: begin
            if (!cur.ready_flag) begin
              done = 1'b1; st = ST_NOT_READY;
            end else begin
              n.poll_counter = '0; n.phase = PH_SYNC;
            end
          end
          default: begin
            done = 1'b1; st = cur.ready_flag ? ST_OK : ST_NOT_READY;
          end
        endcase
      end
    end else if (cur.phase != PH_IDLE) begin
      unique case (cur.phase)
        PH_WAKE: begin
          n.frame_counter = cur.frame_counter + 4'd1;
          if (n.frame_counter >= 4'd10) n = start_cmd(n, LC_RESET, 32'h0);
        end
        PH_FRAME: begin
          n.frame_counter = cur.frame_counter + 4'd1;
          if (n.frame_counter >= 4'd8) begin
            if (cur.command_index == LC_STOP) n.phase = PH_STUFF;
            else begin
              n.poll_counter = '0; n.response_bytes[39:32] = IDLE_BYTE; n.phase = PH_R1;
            end
          end
        end
        PH_STUFF: begin
          n.poll_counter = '0; n.response_bytes[39:32] = IDLE_BYTE; n.phase = PH_R1;
        end
        PH_R1: begin
          n.poll_counter = cur.poll_counter + 24'd1;
          n.response_bytes[39:32] = miso_byte;
          if (miso_byte != IDLE_BYTE) begin
            if (lc_kind(cmd_sel(cur.command_index)) == AK_R7 ||
                lc_kind(cmd_sel(cur.command_index)) == AK_R7_ILLEGAL) begin
              n.frame_counter = '0; n.phase = PH_TAIL;
            end else att = 1'b1;
          end else if (n.poll_counter >= {16'h0, limits.resp_poll}) att = 1'b1;
        end
        PH_TAIL: begin
          n.response_bytes[31:0] = {cur.response_bytes[23:0], miso_byte};
          n.frame_counter = cur.frame_counter + 4'd1;
          if (n.frame_counter >= 4'd4) att = 1'b1;
        end
        PH_TOKEN: begin
          n.poll_counter = cur.poll_counter + 24'd1;
          if (miso_byte == TOKEN_START) begin
            n.byte_counter = '0; n.phase = PH_RDATA;
          end else if (n.poll_counter >= limits.ready_wait) begin
            n.phase = PH_IDLE; done = 1'b1; st = ST_ERROR;
          end
        end
        PH_RDATA: begin
          rvalid = 1'b1;
          n.byte_counter = cur.byte_counter + BLK_STEP;
          if (n.byte_counter >= BLK_BYTES) begin
            n.frame_counter = '0; n.phase = PH_RCRC;
          end
        end
        PH_RCRC: begin
          n.frame_counter = cur.frame_counter + 4'd1;
          if (n.frame_counter >= 4'd2) begin
            n.blocks_left = cur.blocks_left - 8'd1;
            if (n.blocks_left == 8'd0) begin
              if (cur.command_index == LC_READ_MANY) n = start_cmd(n, LC_STOP, 32'h0);
              else begin
                n.poll_counter = '0; n.phase = PH_SETTLE_OK;
              end
            end else begin
              n.poll_counter = '0; n.phase = PH_TOKEN;
            end
          end
        end
        PH_SETTLE_OK, PH_SETTLE_ERR: begin
          n.poll_counter = cur.poll_counter + 24'd1;
          if (miso_byte == IDLE_BYTE || n.poll_counter >= limits.ready_wait) begin
            n.phase = PH_IDLE; done = 1'b1;
            st = (cur.phase == PH_SETTLE_OK) ? ST_OK : ST_ERROR;
          end
        end
        PH_SYNC: begin
          n.poll_counter = cur.poll_counter + 24'd1;
          if (miso_byte == IDLE_BYTE) begin
            n.phase = PH_IDLE; done = 1'b1; st = ST_OK;
          end else if (n.poll_counter >= limits.ready_wait) begin
            n.phase = PH_IDLE; done = 1'b1; st = ST_ERROR;
          end
        end
        PH_WPRE: n.phase = PH_WTOKEN;
        PH_WTOKEN: begin
          n.byte_counter = '0; n.phase = PH_WDATA;
        end
        PH_WDATA: begin
          n.byte_counter = cur.byte_counter + BLK_STEP;
          if (n.byte_counter >= BLK_BYTES) begin
            n.frame_counter = '0; n.phase = PH_WCRC;
          end
        end
        PH_WCRC: begin
          n.frame_counter = cur.frame_counter + 4'd1;
          if (n.frame_counter >= 4'd2) begin
            n.poll_counter = '0; n.phase = PH_WRESP;
          end
        end
        PH_WRESP: begin
          n.poll_counter = cur.poll_counter + 24'd1;
          if (miso_byte != IDLE_BYTE) begin
            n.poll_counter = '0;
            n.phase = (miso_byte[3:0] == DATA_ACCEPTED) ? PH_WBUSY : PH_SETTLE_ERR;
          end else if (n.poll_counter >= limits.ready_wait) begin
            n.poll_counter = '0; n.phase = PH_SETTLE_ERR;
          end
        end
        PH_WBUSY: begin
          n.poll_counter = cur.poll_counter + 24'd1;
          if (miso_byte != 8'd0) begin
            n.blocks_left = cur.blocks_left - 8'd1;
            if (n.blocks_left == 8'd0) begin
              n.poll_counter = '0; n.phase = PH_SETTLE_OK;
            end else begin
              n.card_address = cur.card_address +
                               (cur.uses_block_address ? 32'd1 : 32'(BLOCK_BYTES));
              n = start_cmd(n, LC_WRITE_ONE, n.card_address);
            end
          end else if (n.poll_counter >= limits.ready_wait) begin
            n.poll_counter = '0; n.phase = PH_SETTLE_ERR;
          end
        end
        default: n.phase = PH_IDLE;
      endcase
    end

    // End of one command attempt: judge the answer, retry or move on.
    if (att) begin
      r1 = n.response_bytes[39:32];
      unique case (lc_kind(cmd_sel(n.command_index)))
        AK_R1: acc = (r1 != IDLE_BYTE);
        AK_R7: acc = (r1 <= 8'd1);
        AK_R7_ILLEGAL: acc = (r1 <= 8'd1) || (r1 != IDLE_BYTE && r1[2]);
        default: acc = (r1 == 8'd0);
      endcase
      if (acc) cmd_done = 1'b1;
      else begin
        n.attempt_counter = n.attempt_counter + 8'd1;
        if (n.attempt_counter >= limits.cmd_retry) cmd_done = 1'b1;
        else begin
          n.frame_counter = '0; n.phase = PH_FRAME;
        end
      end
    end

    if (cmd_done) begin
      c = cmd_sel(n.command_index);
      unique case (c)
        LC_RESET: begin
          if (r1 == 8'd1) n = start_cmd(n, LC_IFCOND, 32'h1AA);
          else begin
            n.phase = PH_IDLE; done = 1'b1; st = ST_NOT_READY;
          end
        end
        LC_IFCOND: begin
          n.version_two_card = !r1[2];
          n = start_cmd(n, LC_OCR_FIRST, 32'h0);
        end
        LC_OCR_FIRST: begin
          n.init_counter = '0;
          n = start_cmd(n, n.version_two_card ? LC_APP : LC_OPCOND, 32'h0);
        end
        LC_APP, LC_APP_OPCOND, LC_OPCOND: begin
          if (c == LC_APP && (r1 == 8'd0 || r1 == 8'd1)) begin
            n = start_cmd(n, LC_APP_OPCOND, 32'h4000_0000);
          end else if (c == LC_APP_OPCOND && r1 == 8'd0) begin
            n = start_cmd(n, LC_OCR_LAST, 32'h0);
          end else if (c == LC_OPCOND && r1 == 8'd0) begin
            n.ready_flag = 1'b1; n.phase = PH_IDLE; done = 1'b1; st = ST_OK;
          end else begin
            // A failed pass of the initialisation loop.
            n.init_counter = n.init_counter + 16'd1;
            if (n.init_counter >= limits.init_attempt) begin
              n.phase = PH_IDLE; done = 1'b1; st = ST_NOT_READY;
            end else n = start_cmd(n, n.version_two_card ? LC_APP : LC_OPCOND, 32'h0);
          end
        end
        LC_OCR_LAST: begin
          n.phase = PH_IDLE; done = 1'b1;
          if (!n.response_bytes[31]) st = ST_NOT_READY;
          else begin
            n.uses_block_address = n.response_bytes[30];
            n.ready_flag = 1'b1; st = ST_OK;
          end
        end
        LC_READ_ONE, LC_READ_MANY: begin
          if (r1 != 8'd0) begin
            n.phase = PH_IDLE; done = 1'b1; st = ST_ERROR;
          end else begin
            n.poll_counter = '0; n.phase = PH_TOKEN;
          end
        end
        LC_STOP: begin
          n.poll_counter = '0; n.phase = PH_SETTLE_OK;
        end
        default: begin
          if (r1 != 8'd0) begin
            n.poll_counter = '0; n.phase = PH_SETTLE_ERR;
          end else n.phase = PH_WPRE;
        end
      endcase
    end

    busy = !ignored && n.phase != PH_IDLE;
    c = cmd_sel(n.command_index);
    if (busy) begin
      if (n.phase == PH_FRAME) begin
        if (n.frame_counter < 4'd2) mosi = IDLE_BYTE;
        else if (n.frame_counter == 4'd2) mosi = 8'h40 | lc_opcode(c);
        else if (n.frame_counter == 4'd3) mosi = n.command_argument[31:24];
        else if (n.frame_counter == 4'd4) mosi = n.command_argument[23:16];
        else if (n.frame_counter == 4'd5) mosi = n.command_argument[15:8];
        else if (n.frame_counter == 4'd6) mosi = n.command_argument[7:0];
        else mosi = lc_crc(c);
      end else if (n.phase == PH_WTOKEN) mosi = TOKEN_START;
      else if (n.phase == PH_WDATA) mosi = write_byte;
    end

    nxt = n;
    res.mosi_byte = mosi;
    res.exchange_request = busy;
    res.chip_select_low = busy && n.phase != PH_WAKE;
    res.read_data = rvalid ? miso_byte : 8'h0;
    res.read_valid = rvalid;
    res.write_taken = busy && n.phase == PH_WDATA;
    res.done_res = done;
    res.status = done ? st : ST_OK;
    res.initialized = n.ready_flag;
    res.block_addressing = n.uses_block_address;
    res.fast_clock = n.ready_flag;
  end

endmodule

// ----- sv/sd_card_spi_host_engine_top.sv -----
// SD card SPI host engine: top level with state and result registers.
// Each transaction is either a host request or the byte the card returned in
// the previous exchange; each yields exactly one result naming the next byte to
// send. A transaction is taken every clock cycle while out_ready does not stall:
// the sequencer state and the result register are loaded together, and a new
// transaction is accepted while the previous result is still waiting, provided
// it is taken in the same cycle. The user must set limits through the register
// port only while the engine is idle; the block itself does not enforce this. A limit of zero behaves as one.
module sd_card_spi_host_engine_top
  import sdsh_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [2:0]  in_operation,
  input  logic [7:0]  in_drive,
  input  logic [31:0] in_start_sector,
  input  logic [7:0]  in_block_count,
  input  logic [7:0]  in_miso_byte,
  input  logic [7:0]  in_write_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_mosi_byte,
  output logic        out_exchange_request,
  output logic        out_chip_select_low,
  output logic [7:0]  out_read_data,
  output logic        out_read_valid,
  output logic        out_write_taken,
  output logic        out_done_res,
  output logic [1:0]  out_status,
  output logic        out_initialized,
  output logic        out_block_addressing,
  output logic        out_fast_clock,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  sdsh_limits_t limits;
  sdsh_state_t  state_r, state_nxt;
  sdsh_result_t res_r, res_nxt;
  logic         out_valid_r;
  logic         accept;

  assign cfg_pready = 1'b1;

  sdsh_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata),
    .prdata(cfg_prdata), .limits(limits)
  );

  sdsh_step #(.MAX_BLOCKS(MAX_BLOCKS)) u_step (
    .cur(state_r), .limits(limits), .mode(in_mode), .operation(in_operation),
    .drive(in_drive), .start_sector(in_start_sector), .block_count(in_block_count),
    .miso_byte(in_miso_byte), .write_byte(in_write_byte),
    .nxt(state_nxt), .res(res_nxt)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      state_r.phase <= PH_IDLE;
      state_r.command_index <= '0;
      state_r.frame_counter <= '0;
      state_r.command_argument <= '0;
      state_r.response_bytes <= '1;
      state_r.attempt_counter <= '0;
      state_r.poll_counter <= '0;
      state_r.init_counter <= '0;
      state_r.byte_counter <= '0;
      state_r.blocks_left <= '0;
      state_r.card_address <= '0;
      state_r.version_two_card <= 1'b0;
      state_r.uses_block_address <= 1'b0;
      state_r.ready_flag <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
      state_r <= state_nxt;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_mosi_byte = res_r.mosi_byte;
  assign out_exchange_request = res_r.exchange_request;
  assign out_chip_select_low = res_r.chip_select_low;
  assign out_read_data = res_r.read_data;
  assign out_read_valid = res_r.read_valid;
  assign out_write_taken = res_r.write_taken;
  assign out_done_res = res_r.done_res;
  assign out_status = res_r.status;
  assign out_initialized = res_r.initialized;
  assign out_block_addressing = res_r.block_addressing;
  assign out_fast_clock = res_r.fast_clock;

endmodule

// ----- sv/sdsh_checker.sv -----
// Port-level checker for the SD card SPI host engine and its binding.
module sdsh_checker
  import sdsh_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_mosi_byte,
  input logic       out_exchange_request,
  input logic       out_chip_select_low,
  input logic       out_write_taken,
  input logic       out_done_res,
  input logic [1:0] out_status,
  input logic       out_initialized,
  input logic       out_fast_clock
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mosi_byte) && $stable(out_status))
    else $error("result changed while stalled");

  a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_status == ST_OK)
    else $error("status without completion");

  a_no_exchange: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_exchange_request |-> out_mosi_byte == IDLE_BYTE && !out_chip_select_low
      && !out_write_taken)
    else $error("byte driven without exchange");

  a_fast_clock: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fast_clock == out_initialized)
    else $error("clock select disagrees with init state");

  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_exchange_request)
    else $error("exchange requested on completion");

endmodule

bind sd_card_spi_host_engine_top sdsh_checker u_sdsh_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_mosi_byte(out_mosi_byte), .out_exchange_request(out_exchange_request),
  .out_chip_select_low(out_chip_select_low), .out_write_taken(out_write_taken),
  .out_done_res(out_done_res), .out_status(out_status),
  .out_initialized(out_initialized), .out_fast_clock(out_fast_clock)
);

// ----- verif/sd_card_spi_host_engine_top_test.sv -----
// Self-checking testbench of the SD card SPI host engine, with a card responder.
`timescale 1ns / 100ps

module sd_card_spi_host_engine_top_test
  import sdsh_pkg::*;
;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_mode;
  logic [2:0]  in_operation;
  logic [7:0]  in_drive;
  logic [31:0] in_start_sector;
  logic [7:0]  in_block_count;
  logic [7:0]  in_miso_byte;
  logic [7:0]  in_write_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_mosi_byte;
  logic        out_exchange_request;
  logic        out_chip_select_low;
  logic [7:0]  out_read_data;
  logic        out_read_valid;
  logic        out_write_taken;
  logic        out_done_res;
  logic [1:0]  out_status;
  logic        out_initialized;
  logic        out_block_addressing;
  logic        out_fast_clock;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  sd_card_spi_host_engine_top DUT (.*);

  // Mirror of the sequencer state and limits.
  phase_t      ph;
  logic [3:0]  cmd_idx;
  logic [3:0]  frame_cnt;
  logic [31:0] cmd_arg;
  logic [39:0] resp;
  logic [7:0]  attempts;
  logic [23:0] polls;
  logic [15:0] init_passes;
  logic [9:0]  data_cnt;
  logic [7:0]  blocks_left;
  logic [31:0] card_addr;
  logic        card_v2;
  logic        block_addr;
  logic        card_ready;
  logic [7:0]  lim_retry;
  logic [7:0]  lim_poll;
  logic [15:0] lim_init;
  logic [23:0] lim_wait;
  logic        r_done;
  logic        r_rvalid;
  logic [1:0]  r_status;
  logic [7:0]  r_rdata;
  logic        item_ignored;

  sdsh_result_t expected_results[$];
  int unsigned  error_count;
  int unsigned  cycle_count;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;

  function automatic logic [7:0] opcode_for(logic [3:0] c);
    case (c)
      LC_IFCOND: return 8'd8;
      LC_OCR_FIRST, LC_OCR_LAST: return 8'd58;
      LC_APP: return 8'd55;
      LC_APP_OPCOND: return 8'd41;
      LC_OPCOND: return 8'd1;
      LC_READ_ONE: return 8'd17;
      LC_READ_MANY: return 8'd18;
      LC_STOP: return 8'd12;
      LC_WRITE_ONE: return 8'd24;
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [1:0] answer_kind(logic [3:0] c);
    case (c)
      LC_IFCOND: return AK_R7_ILLEGAL;
      LC_OCR_FIRST, LC_OCR_LAST: return AK_R7;
      LC_WRITE_ONE: return AK_R1_ZERO;
      default: return AK_R1;
    endcase
  endfunction

  function automatic void end_request(logic [1:0] st);
    ph = PH_IDLE;
    r_done = 1'b1;
    r_status = st;
  endfunction

  function automatic void launch_cmd(logic [3:0] lc, logic [31:0] a);
    cmd_idx = lc;
    cmd_arg = a;
    attempts = '0;
    frame_cnt = '0;
    resp = {8'hFF, 32'h0};
    ph = PH_FRAME;
  endfunction

  function automatic void go_settle(logic ok);
    polls = '0;
    if (ok) ph = PH_SETTLE_OK;
    else ph = PH_SETTLE_ERR;
  endfunction

  function automatic void init_pass();
    launch_cmd(card_v2 ? LC_APP : LC_OPCOND, 32'h0);
  endfunction

  function automatic void init_pass_failed();
    init_passes++;
    if (init_passes >= lim_init) end_request(ST_NOT_READY);
    else init_pass();
  endfunction

  function automatic void init_succeeded();
    card_ready = 1'b1;
    end_request(ST_OK);
  endfunction

  function automatic void command_finished();
    logic [7:0] r1;
    r1 = resp[39:32];
    case (cmd_idx)
      LC_RESET: begin
        if (r1 == 8'd1) launch_cmd(LC_IFCOND, 32'h1AA);
        else end_request(ST_NOT_READY);
      end
      LC_IFCOND: begin
        card_v2 = (r1[2] == 1'b0);
        launch_cmd(LC_OCR_FIRST, 32'h0);
      end
      LC_OCR_FIRST: begin
        init_passes = '0;
        init_pass();
      end
      LC_APP: begin
        if (r1 != 8'd0 && r1 != 8'd1) init_pass_failed();
        else launch_cmd(LC_APP_OPCOND, 32'h4000_0000);
      end
      LC_APP_OPCOND: begin
        if (r1 == 8'd0) launch_cmd(LC_OCR_LAST, 32'h0);
        else init_pass_failed();
      end
      LC_OPCOND: begin
        if (r1 == 8'd0) init_succeeded();
        else init_pass_failed();
      end
      LC_OCR_LAST: begin
        if (!resp[31]) end_request(ST_NOT_READY);
        else begin
          block_addr = resp[30];
          init_succeeded();
        end
      end
      LC_READ_ONE, LC_READ_MANY: begin
        if (r1 != 8'd0) end_request(ST_ERROR);
        else begin
          polls = '0;
          ph = PH_TOKEN;
        end
      end
      LC_STOP: go_settle(1'b1);
      default: begin
        if (r1 != 8'd0) go_settle(1'b0);
        else ph = PH_WPRE;
      end
    endcase
  endfunction

  function automatic logic answer_ok();
    logic [7:0] r1;
    r1 = resp[39:32];
    case (answer_kind(cmd_idx))
      AK_R1: return r1 != 8'hFF;
      AK_R7: return r1 <= 8'd1;
      AK_R7_ILLEGAL: return r1 <= 8'd1 || (r1 != 8'hFF && r1[2]);
      default: return r1 == 8'd0;
    endcase
  endfunction

  function automatic void attempt_finished();
    if (answer_ok()) begin
      command_finished();
      return;
    end
    attempts++;
    if (attempts >= lim_retry) command_finished();
    else begin
      frame_cnt = '0;
      ph = PH_FRAME;
    end
  endfunction

  function automatic void take_card_byte(logic [7:0] b);
    case (ph)
      PH_WAKE: begin
        frame_cnt++;
        if (frame_cnt >= 10) launch_cmd(LC_RESET, 32'h0);
      end
      PH_FRAME: begin
        frame_cnt++;
        if (frame_cnt >= 8) begin
          if (cmd_idx == LC_STOP) ph = PH_STUFF;
          else begin
            polls = '0;
            resp[39:32] = 8'hFF;
            ph = PH_R1;
          end
        end
      end
      PH_STUFF: begin
        polls = '0;
        resp[39:32] = 8'hFF;
        ph = PH_R1;
      end
      PH_R1: begin
        polls++;
        resp[39:32] = b;
        if (b != 8'hFF) begin
          if (answer_kind(cmd_idx) == AK_R7 || answer_kind(cmd_idx) == AK_R7_ILLEGAL) begin
            frame_cnt = '0;
            ph = PH_TAIL;
          end else attempt_finished();
        end else if (polls >= lim_poll) attempt_finished();
      end
      PH_TAIL: begin
        resp = {resp[39:32], resp[23:0], b};
        frame_cnt++;
        if (frame_cnt >= 4) attempt_finished();
      end
      PH_TOKEN: begin
        polls++;
        if (b == TOKEN_START) begin
          data_cnt = '0;
          ph = PH_RDATA;
        end else if (polls >= lim_wait) end_request(ST_ERROR);
      end
      PH_RDATA: begin
        r_rvalid = 1'b1;
        r_rdata = b;
        data_cnt++;
        if (data_cnt >= BLOCK_BYTES) begin
          frame_cnt = '0;
          ph = PH_RCRC;
        end
      end
      PH_RCRC: begin
        frame_cnt++;
        if (frame_cnt >= 2) begin
          blocks_left--;
          if (blocks_left == 0) begin
            if (cmd_idx == LC_READ_MANY) launch_cmd(LC_STOP, 32'h0);
            else go_settle(1'b1);
          end else begin
            polls = '0;
            ph = PH_TOKEN;
          end
        end
      end
      PH_SETTLE_OK, PH_SETTLE_ERR: begin
        polls++;
        if (b == 8'hFF || polls >= lim_wait)
          end_request(ph == PH_SETTLE_OK ? ST_OK : ST_ERROR);
      end
      PH_SYNC: begin
        polls++;
        if (b == 8'hFF) end_request(ST_OK);
        else if (polls >= lim_wait) end_request(ST_ERROR);
      end
      PH_WPRE: ph = PH_WTOKEN;
      PH_WTOKEN: begin
        data_cnt = '0;
        ph = PH_WDATA;
      end
      PH_WDATA: begin
        data_cnt++;
        if (data_cnt >= BLOCK_BYTES) begin
          frame_cnt = '0;
          ph = PH_WCRC;
        end
      end
      PH_WCRC: begin
        frame_cnt++;
        if (frame_cnt >= 2) begin
          polls = '0;
          ph = PH_WRESP;
        end
      end
      PH_WRESP: begin
        polls++;
        if (b != 8'hFF) begin
          if (b[3:0] == DATA_ACCEPTED) begin
            polls = '0;
            ph = PH_WBUSY;
          end else go_settle(1'b0);
        end else if (polls >= lim_wait) go_settle(1'b0);
      end
      PH_WBUSY: begin
        polls++;
        if (b != 8'd0) begin
          blocks_left--;
          if (blocks_left == 0) go_settle(1'b1);
          else begin
            card_addr += block_addr ? 32'd1 : 32'd512;
            launch_cmd(LC_WRITE_ONE, card_addr);
          end
        end else if (polls >= lim_wait) go_settle(1'b0);
      end
      default: ph = PH_IDLE;
    endcase
  endfunction

  function automatic void take_request(logic [2:0] op, logic [7:0] drv, logic [31:0] sec,
                                       logic [7:0] cnt);
    if (op > OP_STATUS || drv != 8'd0) begin
      end_request(ST_PARAM);
      return;
    end
    case (op)
      OP_INIT: begin
        card_ready = 1'b0;
        card_v2 = 1'b0;
        block_addr = 1'b0;
        frame_cnt = '0;
        ph = PH_WAKE;
      end
      OP_READ, OP_WRITE: begin
        if (cnt == 0 || cnt > MAX_BLOCKS_DEF) end_request(ST_PARAM);
        else if (!card_ready) end_request(ST_NOT_READY);
        else begin
          blocks_left = cnt;
          card_addr = block_addr ? sec : {sec[22:0], 9'd0};
          if (op == OP_WRITE) launch_cmd(LC_WRITE_ONE, card_addr);
          else launch_cmd(cnt == 1 ? LC_READ_ONE : LC_READ_MANY, card_addr);
        end
      end
      OP_SYNC: begin
        if (!card_ready) end_request(ST_NOT_READY);
        else begin
          polls = '0;
          ph = PH_SYNC;
        end
      end
      default: end_request(card_ready ? ST_OK : ST_NOT_READY);
    endcase
  endfunction

  function automatic logic [7:0] frame_out();
    if (frame_cnt < 2) return 8'hFF;
    if (frame_cnt == 2) return 8'h40 | opcode_for(cmd_idx);
    if (frame_cnt <= 6) return 8'(cmd_arg >> (8 * (6 - frame_cnt)));
    if (cmd_idx == LC_RESET) return 8'h95;
    if (cmd_idx == LC_IFCOND) return 8'h87;
    return 8'h01;
  endfunction

  function automatic sdsh_result_t predict_exchange(logic mode, logic [2:0] op,
      logic [7:0] drv, logic [31:0] sec, logic [7:0] cnt, logic [7:0] miso, logic [7:0] wb);
    sdsh_result_t r;
    logic busy;
    r_done = 1'b0;
    r_rvalid = 1'b0;
    r_status = ST_OK;
    r_rdata = 8'd0;
    item_ignored = 1'b0;
    if (!mode) begin
      if (ph == PH_IDLE) take_request(op, drv, sec, cnt);
      else item_ignored = 1'b1;
    end else if (ph != PH_IDLE) take_card_byte(miso);
    else item_ignored = 1'b1;
    busy = !(item_ignored && !mode) && ph != PH_IDLE;
    r.mosi_byte = 8'hFF;
    r.write_taken = 1'b0;
    if (busy) begin
      if (ph == PH_FRAME) r.mosi_byte = frame_out();
      else if (ph == PH_WTOKEN) r.mosi_byte = TOKEN_START;
      else if (ph == PH_WDATA) begin
        r.mosi_byte = wb;
        r.write_taken = 1'b1;
      end
    end
    r.exchange_request = busy;
    r.chip_select_low = busy && ph != PH_WAKE;
    r.read_data = r_rdata;
    r.read_valid = r_rvalid;
    r.done_res = r_done;
    r.status = r_status;
    r.initialized = card_ready;
    r.block_addressing = block_addr;
    r.fast_clock = card_ready;
    return r;
  endfunction

  // Plausible card behaviour for the byte the sequencer is waiting on.
  function automatic logic [7:0] card_reply();
    int unsigned p;
    p = $urandom_range(0, 99);
    case (ph)
      PH_R1: begin
        if (p < 25) return 8'hFF;
        p = $urandom_range(0, 99);
        case (cmd_idx)
          LC_RESET: return p < 85 ? 8'd1 : 8'($urandom);
          LC_IFCOND: return p < 50 ? 8'd1 : (p < 85 ? 8'h05 : 8'($urandom));
          LC_OCR_FIRST, LC_OCR_LAST: return p < 45 ? 8'd0 : (p < 90 ? 8'd1 : 8'($urandom));
          LC_APP: return p < 90 ? 8'd1 : 8'($urandom);
          LC_APP_OPCOND, LC_OPCOND: return p < 50 ? 8'd0 : (p < 90 ? 8'd1 : 8'($urandom));
          LC_STOP: return 8'($urandom);
          default: return p < 88 ? 8'd0 : 8'($urandom);
        endcase
      end
      PH_TAIL: return (frame_cnt == 0 && p < 80) ? (8'h80 | 8'($urandom)) : 8'($urandom);
      PH_TOKEN: return p < 70 ? TOKEN_START : 8'($urandom);
      PH_SETTLE_OK, PH_SETTLE_ERR, PH_SYNC: return p < 50 ? 8'hFF : 8'($urandom);
      PH_WRESP: begin
        if (p < 30) return 8'hFF;
        if (p < 90) return {4'($urandom), DATA_ACCEPTED};
        return 8'($urandom);
      end
      PH_WBUSY: return p < 60 ? 8'd0 : 8'($urandom);
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = 1'b0;
    in_operation = OP_STATUS;
    in_drive = 8'd0;
    in_start_sector = 32'd0;
    in_block_count = 8'd0;
    in_miso_byte = 8'hFF;
    in_write_byte = 8'd0;
    out_ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
  end

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic compare_field(string name, logic [7:0] e, logic [7:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, e, a);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    sdsh_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, mosi %0h", $time, out_mosi_byte);
        error_count++;
      end else begin
        e = expected_results.pop_front();
        compare_field("mosi_byte", e.mosi_byte, out_mosi_byte);
        compare_field("exchange_request", e.exchange_request, out_exchange_request);
        compare_field("chip_select_low", e.chip_select_low, out_chip_select_low);
        compare_field("read_data", e.read_data, out_read_data);
        compare_field("read_valid", e.read_valid, out_read_valid);
        compare_field("write_taken", e.write_taken, out_write_taken);
        compare_field("done_res", e.done_res, out_done_res);
        compare_field("status", e.status, out_status);
        compare_field("initialized", e.initialized, out_initialized);
        compare_field("block_addressing", e.block_addressing, out_block_addressing);
        compare_field("fast_clock", e.fast_clock, out_fast_clock);
      end
    end
  end

  task automatic send_exchange(logic mode, logic [2:0] op, logic [7:0] drv,
      logic [31:0] sec, logic [7:0] cnt, logic [7:0] miso, logic [7:0] wb);
    @(negedge clk);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_mode <= mode;
    in_operation <= op;
    in_drive <= drv;
    in_start_sector <= sec;
    in_block_count <= cnt;
    in_miso_byte <= miso;
    in_write_byte <= wb;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_exchange(mode, op, drv, sec, cnt, miso, wb));
  endtask

  task automatic wait_results_drained(int unsigned settle_cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (settle_cycles) @(negedge clk);
  endtask

  task automatic write_limit(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_CMD_RETRY: lim_retry = value[7:0];
      REG_RESP_POLL: lim_poll = value[7:0];
      REG_INIT_ATTEMPT: lim_init = value[15:0];
      default: lim_wait = value[23:0];
    endcase
  endtask

  task automatic set_limits(logic [7:0] retry, logic [7:0] poll, logic [15:0] passes,
                            logic [23:0] wait_bytes);
    wait_results_drained(8);
    write_limit(REG_CMD_RETRY, {24'h0, retry});
    write_limit(REG_RESP_POLL, {24'h0, poll});
    write_limit(REG_INIT_ATTEMPT, {16'h0, passes});
    write_limit(REG_READY_WAIT, {8'h0, wait_bytes});
  endtask

  // Requests refused before any card activity, and card bytes while idle.
  task automatic test_request_checks();
    send_exchange(1'b0, OP_STATUS, 8'd0, 32'd0, 8'd1, 8'h00, 8'h00);
    send_exchange(1'b0, OP_READ, 8'd0, 32'hFFFF_FFFF, 8'd0, 8'h00, 8'hFF);
    send_exchange(1'b0, OP_READ, 8'd0, 32'd0, 8'd255, 8'hFF, 8'h00);
    send_exchange(1'b0, OP_READ, 8'd0, 32'h8000_0001, 8'd128, 8'h00, 8'h00);
    send_exchange(1'b0, OP_WRITE, 8'd0, 32'd5, 8'd1, 8'h00, 8'h00);
    send_exchange(1'b0, OP_SYNC, 8'd0, 32'd0, 8'd1, 8'h00, 8'h00);
    send_exchange(1'b0, 3'd5, 8'd0, 32'd0, 8'd1, 8'h00, 8'h00);
    send_exchange(1'b0, 3'd6, 8'd0, 32'd0, 8'd1, 8'h00, 8'h00);
    send_exchange(1'b0, 3'd7, 8'd0, 32'd0, 8'd1, 8'h00, 8'h00);
    send_exchange(1'b0, OP_INIT, 8'hFF, 32'd0, 8'd1, 8'h00, 8'h00);
    send_exchange(1'b0, OP_STATUS, 8'h01, 32'd0, 8'd1, 8'h00, 8'h00);
    send_exchange(1'b1, OP_INIT, 8'd0, 32'd0, 8'd1, 8'h00, 8'h00);
    send_exchange(1'b1, OP_INIT, 8'd0, 32'd0, 8'd1, 8'hFF, 8'hFF);
  endtask

  // Request sequences driven to completion by the card responder.
  task automatic test_card_traffic(int unsigned target, int unsigned s_idle,
                                   int unsigned r_idle);
    int unsigned counted;
    int unsigned p;
    logic [2:0] op;
    logic [7:0] drv;
    logic [7:0] cnt;
    counted = 0;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    while (counted < target || ph != PH_IDLE) begin
      p = $urandom_range(0, 99);
      if (ph == PH_IDLE && p >= 8) begin
        p = $urandom_range(0, 99);
        op = p < 22 ? OP_INIT : p < 50 ? OP_READ : p < 80 ? OP_WRITE :
             p < 90 ? OP_SYNC : p < 96 ? OP_STATUS : 3'($urandom_range(5, 7));
        drv = $urandom_range(0, 99) < 4 ? 8'($urandom_range(1, 255)) : 8'd0;
        p = $urandom_range(0, 99);
        cnt = p < 80 ? 8'd1 : p < 95 ? 8'd2 : p < 97 ? 8'd0 : 8'($urandom_range(129, 255));
        send_exchange(1'b0, op, drv, 32'($urandom), cnt, 8'($urandom), 8'($urandom));
      end else if (ph != PH_IDLE && p < 3) begin
        send_exchange(1'b0, 3'($urandom_range(0, 7)), 8'($urandom), 32'($urandom),
                      8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        send_exchange(1'b1, 3'($urandom), 8'($urandom), 32'($urandom), 8'($urandom),
                      card_reply(), 8'($urandom));
      end
      if (!item_ignored) counted++;
      if (counted % 97 == 50 && !item_ignored) wait_results_drained(0);
    end
  endtask

  initial begin
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 25;
    recv_idle_pct = 52;
    ph = PH_IDLE;
    cmd_idx = '0;
    frame_cnt = '0;
    cmd_arg = '0;
    resp = '1;
    attempts = '0;
    polls = '0;
    init_passes = '0;
    data_cnt = '0;
    blocks_left = '0;
    card_addr = '0;
    card_v2 = 1'b0;
    block_addr = 1'b0;
    card_ready = 1'b0;
    lim_retry = CMD_RETRY_RST;
    lim_poll = RESP_POLL_RST;
    lim_init = INIT_ATTEMPT_RST;
    lim_wait = READY_WAIT_RST;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_request_checks();
    test_card_traffic(400, 25, 52);
    set_limits(8'd1, 8'd1, 16'd1, 24'd1);
    test_card_traffic(150, 52, 25);
    set_limits(8'd3, 8'd4, 16'd20, 24'd6);
    test_card_traffic(250, 52, 25);
    set_limits(8'd255, 8'd255, 16'd65535, 24'd16777215);
    test_card_traffic(400, 0, 0);
    wait_results_drained(10);
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
